// ===== sv/rvq_pkg.sv =====
// Package: widths, angle constants, arctangent table and stage types.
`default_nettype none
package rvq_pkg;

  localparam int CW         = 24;
  localparam int QW         = 18;
  localparam int SQW        = 47;
  localparam int SUMW       = 48;
  localparam int NW         = 64;
  localparam int ROOTW      = 32;
  localparam int REMW       = 34;
  localparam int ZW         = 36;
  localparam int XYW        = 34;
  localparam int PRODW      = CW + XYW;
  localparam int MAGW       = 58;
  localparam int DW         = 38;
  localparam int SQ_STAGES  = 32;
  localparam int CORDIC_N   = 30;
  localparam int DIV_STAGES = 18;

  localparam logic signed [ZW-1:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0]  TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [XYW-1:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [QW-1:0]  ONE_Q16     = 18'sd65536;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } rvq_tag_t;

  typedef struct packed {
    logic                 zero;
    logic signed [QW-1:0] w;
  } rvq_tail_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:  a = 36'sd843314857;
      5'd1:  a = 36'sd497837829;
      5'd2:  a = 36'sd263043837;
      5'd3:  a = 36'sd133525159;
      5'd4:  a = 36'sd67021687;
      5'd5:  a = 36'sd33543516;
      5'd6:  a = 36'sd16775851;
      5'd7:  a = 36'sd8388437;
      5'd8:  a = 36'sd4194283;
      5'd9:  a = 36'sd2097149;
      5'd10: a = 36'sd1048575;
      5'd11: a = 36'sd524288;
      5'd12: a = 36'sd262144;
      5'd13: a = 36'sd131072;
      5'd14: a = 36'sd65536;
      5'd15: a = 36'sd32768;
      5'd16: a = 36'sd16384;
      5'd17: a = 36'sd8192;
      5'd18: a = 36'sd4096;
      5'd19: a = 36'sd2048;
      5'd20: a = 36'sd1024;
      5'd21: a = 36'sd512;
      5'd22: a = 36'sd256;
      5'd23: a = 36'sd128;
      5'd24: a = 36'sd64;
      5'd25: a = 36'sd32;
      5'd26: a = 36'sd16;
      5'd27: a = 36'sd8;
      5'd28: a = 36'sd4;
      5'd29: a = 36'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rotation_vector_to_quaternion_core.sv =====
// Top level: pipelined rotation vector to unit quaternion converter.
//
//  channel | dir | fields (tdata, low bit up)
//  in_     | in  | rot_x[23:0], rot_y[47:24], rot_z[71:48]
//  out_    | out | quat_w[17:0], quat_x[35:18], quat_y[53:36], quat_z[71:54]
//
// One vector per cycle while the skid register is empty; a full skid stalls the input.
// Depth is set by the 32-stage square root, the 30-stage CORDIC and the
// 18-stage dividers, one bit or one rotation per stage.
// rst_n clears every valid bit; payload registers are not reset.
// A blocked output parks one word in a skid register and freezes the pipe.
`default_nettype none
module rotation_vector_to_quaternion_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // rot_x, rot_y, rot_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam int SQN = rvq_pkg::SQ_STAGES;
  localparam int CRN = rvq_pkg::CORDIC_N;
  localparam int DVN = rvq_pkg::DIV_STAGES;

  logic en;
  logic skid_v_r;
  logic out_v_r;
  logic [71:0] skid_r;
  logic [71:0] out_r;

  assign en        = ~skid_v_r;
  assign in_tready = en;

  // square stage
  logic                   v1_r;
  rvq_pkg::rvq_tag_t      tag1_r;
  logic [rvq_pkg::SQW-1:0] sq_r [3];
  logic signed [2*rvq_pkg::CW-1:0] sqf [3];
  logic signed [rvq_pkg::CW-1:0] cin [3];

  assign cin[0] = in_tdata[23:0];
  assign cin[1] = in_tdata[47:24];
  assign cin[2] = in_tdata[71:48];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqf[k] = cin[k] * cin[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
    if (en) begin
      tag1_r.zero <= 1'b0;
      tag1_r.cx   <= cin[0];
      tag1_r.cy   <= cin[1];
      tag1_r.cz   <= cin[2];
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= sqf[k][rvq_pkg::SQW-1:0];
      end
    end
  end

  // sum and square root
  logic                     sv_r   [0:SQN];
  rvq_pkg::rvq_tag_t        stag_r [0:SQN];
  logic [rvq_pkg::NW-1:0]   sn_r   [0:SQN];
  logic [rvq_pkg::REMW-1:0] srem_r [0:SQN];
  logic [rvq_pkg::ROOTW-1:0] sroot_r [0:SQN];

  genvar gi;
  generate
    for (gi = 0; gi <= SQN; gi++) begin : g_sqrt
      if (gi == 0) begin : g_sum
        logic [rvq_pkg::SUMW-1:0] sum;
        rvq_pkg::rvq_tag_t        tag0;
        assign sum = {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
        always_comb begin
          tag0      = tag1_r;
          tag0.zero = (sum == '0);
        end
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            sv_r[0] <= 1'b0;
          end else if (en) begin
            sv_r[0] <= v1_r;
          end
          if (en) begin
            stag_r[0]      <= tag0;
            sn_r[0]        <= {sum, 16'b0};
            srem_r[0]      <= '0;
            sroot_r[0]     <= '0;
          end
        end
      end else begin : g_bit
        logic [rvq_pkg::REMW-1:0] rin;
        logic [rvq_pkg::REMW-1:0] trial;
        logic                     ge;
        assign rin   = {srem_r[gi-1][rvq_pkg::REMW-3:0], sn_r[gi-1][rvq_pkg::NW-1 -: 2]};
        assign trial = {sroot_r[gi-1], 2'b01};
        assign ge    = (rin >= trial);
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            sv_r[gi] <= 1'b0;
          end else if (en) begin
            sv_r[gi] <= sv_r[gi-1];
          end
          if (en) begin
            stag_r[gi]  <= stag_r[gi-1];
            sn_r[gi]    <= {sn_r[gi-1][rvq_pkg::NW-3:0], 2'b00};
            srem_r[gi]  <= ge ? (rin - trial) : rin;
            sroot_r[gi] <= {sroot_r[gi-1][rvq_pkg::ROOTW-2:0], ge};
          end
        end
      end
    end
  endgenerate

  // range reduction and CORDIC
  logic                      cv_r    [0:CRN];
  rvq_pkg::rvq_tag_t         ctag_r  [0:CRN];
  logic                      cflip_r [0:CRN];
  logic [rvq_pkg::ROOTW-1:0] cang_r  [0:CRN];
  logic signed [rvq_pkg::XYW-1:0] cx_r [0:CRN];
  logic signed [rvq_pkg::XYW-1:0] cy_r [0:CRN];
  logic signed [rvq_pkg::ZW-1:0]  cz_r [0:CRN];

  generate
    for (gi = 0; gi <= CRN; gi++) begin : g_cordic
      if (gi == 0) begin : g_range
        logic signed [rvq_pkg::ZW-1:0] z0, z1, z2;
        logic flip;
        always_comb begin
          z0 = $signed({3'b000, sroot_r[SQN], 1'b0});
          z1 = (z0 > rvq_pkg::PI_Q30) ? z0 - rvq_pkg::TWO_PI_Q30 : z0;
          priority if (z1 > rvq_pkg::HALF_PI_Q30) begin
            z2 = z1 - rvq_pkg::PI_Q30;
            flip = 1'b1;
          end else if (z1 < -rvq_pkg::HALF_PI_Q30) begin
            z2 = z1 + rvq_pkg::PI_Q30;
            flip = 1'b1;
          end else begin
            z2 = z1;
            flip = 1'b0;
          end
        end
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            cv_r[0] <= 1'b0;
          end else if (en) begin
            cv_r[0] <= sv_r[SQN];
          end
          if (en) begin
            ctag_r[0]  <= stag_r[SQN];
            cflip_r[0] <= flip;
            cang_r[0]  <= sroot_r[SQN];
            cx_r[0]    <= rvq_pkg::CORDIC_K;
            cy_r[0]    <= '0;
            cz_r[0]    <= z2;
          end
        end
      end else begin : g_rot
        logic signed [rvq_pkg::XYW-1:0] xs, ys;
        logic signed [rvq_pkg::ZW-1:0]  at;
        assign xs = cx_r[gi-1] >>> (gi-1);
        assign ys = cy_r[gi-1] >>> (gi-1);
        assign at = rvq_pkg::atan_q30(5'(gi-1));
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            cv_r[gi] <= 1'b0;
          end else if (en) begin
            cv_r[gi] <= cv_r[gi-1];
          end
          if (en) begin
            ctag_r[gi]  <= ctag_r[gi-1];
            cflip_r[gi] <= cflip_r[gi-1];
            cang_r[gi]  <= cang_r[gi-1];
            if (!cz_r[gi-1][rvq_pkg::ZW-1]) begin
              cx_r[gi] <= cx_r[gi-1] - ys;
              cy_r[gi] <= cy_r[gi-1] + xs;
              cz_r[gi] <= cz_r[gi-1] - at;
            end else begin
              cx_r[gi] <= cx_r[gi-1] + ys;
              cy_r[gi] <= cy_r[gi-1] - xs;
              cz_r[gi] <= cz_r[gi-1] + at;
            end
          end
        end
      end
    end
  endgenerate

  // unflip, w rounding
  logic                           fv_r;
  rvq_pkg::rvq_tag_t              ftag_r;
  logic [rvq_pkg::ROOTW-1:0]      fang_r;
  logic signed [rvq_pkg::XYW-1:0] fy_r;
  logic signed [rvq_pkg::QW-1:0]  fw_r;
  logic signed [rvq_pkg::XYW-1:0] xf, yf, wr;
  logic signed [rvq_pkg::QW-1:0]  wc;

  always_comb begin
    xf = cflip_r[CRN] ? -cx_r[CRN] : cx_r[CRN];
    yf = cflip_r[CRN] ? -cy_r[CRN] : cy_r[CRN];
    wr = (xf + 34'sd8192) >>> 14;
    priority if (wr > 34'sd65536) begin
      wc = rvq_pkg::ONE_Q16;
    end else if (wr < -34'sd65536) begin
      wc = -rvq_pkg::ONE_Q16;
    end else begin
      wc = wr[rvq_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= cv_r[CRN];
    end
    if (en) begin
      ftag_r <= ctag_r[CRN];
      fang_r <= cang_r[CRN];
      fy_r   <= yf;
      fw_r   <= wc;
    end
  end

  // products
  logic                             mv_r;
  rvq_pkg::rvq_tail_t               mtail_r;
  logic [rvq_pkg::ROOTW-1:0]        mang_r;
  logic signed [rvq_pkg::PRODW-1:0] mprod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= fv_r;
    end
    if (en) begin
      mtail_r.zero <= ftag_r.zero;
      mtail_r.w    <= fw_r;
      mang_r       <= fang_r;
      mprod_r[0]   <= ftag_r.cx * fy_r;
      mprod_r[1]   <= ftag_r.cy * fy_r;
      mprod_r[2]   <= ftag_r.cz * fy_r;
    end
  end

  // magnitude plus half divisor
  logic                      nv_r;
  rvq_pkg::rvq_tail_t        ntail_r;
  logic [rvq_pkg::DW-1:0]    nd_r;
  logic [rvq_pkg::MAGW-1:0]  nmag_r [3];
  logic                      nneg_r [3];
  logic [rvq_pkg::PRODW-1:0] pabs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pabs[k] = mprod_r[k][rvq_pkg::PRODW-1] ? 58'(-mprod_r[k]) : 58'(mprod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= mv_r;
    end
    if (en) begin
      ntail_r <= mtail_r;
      nd_r    <= {mang_r, 6'b0};
      for (int k = 0; k < 3; k++) begin
        nneg_r[k] <= mprod_r[k][rvq_pkg::PRODW-1];
        nmag_r[k] <= pabs[k] + {21'b0, mang_r, 5'b0};
      end
    end
  end

  // restoring dividers, one quotient bit per stage
  logic                     dv_r   [0:DVN];
  rvq_pkg::rvq_tail_t       dtail_r [0:DVN];
  logic [rvq_pkg::DW-1:0]   dd_r   [0:DVN];
  logic [rvq_pkg::MAGW-1:0] drem_r [0:DVN][3];
  logic [rvq_pkg::QW-1:0]   dq_r   [0:DVN][3];
  logic                     dovf_r [0:DVN][3];
  logic                     dneg_r [0:DVN][3];

  generate
    for (gi = 0; gi <= DVN; gi++) begin : g_div
      if (gi == 0) begin : g_ovf
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            dv_r[0] <= 1'b0;
          end else if (en) begin
            dv_r[0] <= nv_r;
          end
          if (en) begin
            dtail_r[0] <= ntail_r;
            dd_r[0]    <= nd_r;
            for (int k = 0; k < 3; k++) begin
              drem_r[0][k] <= nmag_r[k];
              dq_r[0][k]   <= '0;
              dneg_r[0][k] <= nneg_r[k];
              dovf_r[0][k] <= (nmag_r[k] >= {2'b00, nd_r, 18'b0});
            end
          end
        end
      end else begin : g_step
        logic [rvq_pkg::MAGW-1:0] sh;
        logic                     ge [3];
        assign sh = {20'b0, dd_r[gi-1]} << (DVN - gi);
        always_comb begin
          for (int k = 0; k < 3; k++) begin
            ge[k] = (drem_r[gi-1][k] >= sh);
          end
        end
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            dv_r[gi] <= 1'b0;
          end else if (en) begin
            dv_r[gi] <= dv_r[gi-1];
          end
          if (en) begin
            dtail_r[gi] <= dtail_r[gi-1];
            dd_r[gi]    <= dd_r[gi-1];
            for (int k = 0; k < 3; k++) begin
              drem_r[gi][k] <= ge[k] ? drem_r[gi-1][k] - sh : drem_r[gi-1][k];
              dq_r[gi][k]   <= {dq_r[gi-1][k][rvq_pkg::QW-2:0], ge[k]};
              dovf_r[gi][k] <= dovf_r[gi-1][k];
              dneg_r[gi][k] <= dneg_r[gi-1][k];
            end
          end
        end
      end
    end
  endgenerate

  // result word
  logic [rvq_pkg::QW-1:0]        qc  [3];
  logic signed [rvq_pkg::QW-1:0] qs  [3];
  logic [71:0]                   res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dovf_r[DVN][k] || dq_r[DVN][k] > 18'd65536) ? 18'd65536 : dq_r[DVN][k];
      qs[k] = dneg_r[DVN][k] ? -$signed(qc[k]) : $signed(qc[k]);
    end
    if (dtail_r[DVN].zero) begin
      res = {54'b0, rvq_pkg::ONE_Q16};
    end else begin
      res = {qs[2], qs[1], qs[0], dtail_r[DVN].w};
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r | (en & dv_r[DVN]);
      skid_v_r <= 1'b0;
    end else if (en && dv_r[DVN]) begin
      skid_v_r <= 1'b1;
    end
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (en && dv_r[DVN]) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

`ifndef ASSERT_OFF
  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid full without output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled while output free");

  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_r[17:0]) <= 18'sd65536 && $signed(out_r[17:0]) >= -18'sd65536))
    else $error("quat_w out of range");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_r[35:18]) <= 18'sd65536 && $signed(out_r[35:18]) >= -18'sd65536))
    else $error("quat_x out of range");
`endif

endmodule
`default_nettype wire

// ===== verif/rotation_vector_to_quaternion_core_tb.sv =====
// Testbench for the rotation vector to unit quaternion converter.
`timescale 1ns / 1ps
`default_nettype none
module rotation_vector_to_quaternion_core_tb;

  localparam int N_RANDOM   = 830;
  localparam int WATCHDOG   = 3000;
  localparam int DRAIN_WAIT = 120;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic signed [rvq_pkg::CW-1:0] rx;
    logic signed [rvq_pkg::CW-1:0] ry;
    logic signed [rvq_pkg::CW-1:0] rz;
    bit                            typed;
    logic [71:0]                   quat;
  } vec_row_t;

  localparam longint ATAN_TBL [rvq_pkg::CORDIC_N] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  logic [71:0] quat_q [$];
  logic [71:0] pend_q [$];
  int          errors;
  int          n_in;
  int          n_out;
  int          n_ident;
  int          n_negw;
  int          idle_cnt;
  bit          in_fire;
  bit          out_fire;
  bit          hold_done;
  vec_row_t    rows [$];

  rotation_vector_to_quaternion_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // rot_x, rot_y, rot_z
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // quat_w, quat_x, quat_y, quat_z
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint div_nearest(input longint num, input longint d);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + (d >>> 1)) / d;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [71:0] predict_quat(input logic signed [rvq_pkg::CW-1:0] rx,
                                               input logic signed [rvq_pkg::CW-1:0] ry,
                                               input logic signed [rvq_pkg::CW-1:0] rz);
    longint      c [3];
    logic [63:0] sum;
    longint      angle;
    longint      z;
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    longint      d;
    bit          flip;
    logic [17:0] f [4];
    c[0] = rx;
    c[1] = ry;
    c[2] = rz;
    sum = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    if (sum == 0) return {54'd0, 18'd65536};
    angle = longint'(root_floor(sum << 16));
    z = angle * 2;
    flip = 0;
    x = rvq_pkg::CORDIC_K;
    y = 0;
    if (z > rvq_pkg::PI_Q30) z = z - rvq_pkg::TWO_PI_Q30;
    if (z > rvq_pkg::HALF_PI_Q30) begin
      z = z - rvq_pkg::PI_Q30;
      flip = 1;
    end else if (z < -rvq_pkg::HALF_PI_Q30) begin
      z = z + rvq_pkg::PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < rvq_pkg::CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    f[0] = 18'(clamp_unit((x + 8192) >>> 14));
    d = angle * 64;
    if (d <= 0) d = 1;
    for (int i = 0; i < 3; i++) f[i + 1] = 18'(clamp_unit(div_nearest(c[i] * y, d)));
    return {f[3], f[2], f[1], f[0]};
  endfunction

  task automatic report_mismatch(input string field, input logic [17:0] got,
                                 input logic [17:0] want);
    errors++;
    $display("mismatch word %0d %s: got %0d expected %0d", n_out, field,
             $signed(got), $signed(want));
  endtask

  task automatic add_row(input int rx, input int ry, input int rz, input bit typed,
                         input logic [71:0] quat);
    vec_row_t r;
    r.rx = 24'(rx);
    r.ry = 24'(ry);
    r.rz = 24'(rz);
    r.typed = typed;
    r.quat = quat;
    rows = {rows, r};
  endtask

  // accept side and result check
  always @(posedge clk) begin
    logic [71:0] want;
    in_fire = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      in_fire = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;
      if (in_fire || out_fire) idle_cnt = 0;
      else idle_cnt++;
      if (in_fire) begin
        want = predict_quat(in_tdata[23:0], in_tdata[47:24], in_tdata[71:48]);
        if (pend_q.size() != 0) begin
          if (pend_q[0] != want) begin
            errors++;
            $display("table entry %0d disagrees with predicted result", n_in);
          end
          void'(pend_q.pop_front());
        end
        quat_q = {quat_q, want};
        n_in++;
      end
      if (out_fire) begin
        if (quat_q.size() == 0) begin
          errors++;
          $display("unexpected word %0d: %h", n_out, out_tdata);
        end else begin
          want = quat_q.pop_front();
          if (out_tdata[17:0] != want[17:0]) report_mismatch("w", out_tdata[17:0], want[17:0]);
          if (out_tdata[35:18] != want[35:18])
            report_mismatch("x", out_tdata[35:18], want[35:18]);
          if (out_tdata[53:36] != want[53:36])
            report_mismatch("y", out_tdata[53:36], want[53:36]);
          if (out_tdata[71:54] != want[71:54])
            report_mismatch("z", out_tdata[71:54], want[71:54]);
        end
        if (out_tdata[17:0] == 18'd65536 && out_tdata[71:18] == 0) n_ident++;
        if (out_tdata[17]) n_negw++;
        n_out++;
      end
      if (idle_cnt >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    int n;
    out_tready = 1'b0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && n_in > 300) begin
        out_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_done = 1;
      end
      n = ((n_out / 64) % 3 == 0) ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(negedge clk); while (!out_fire);
      if (n == 0) continue;
    end
  end

  task automatic send_vec(input logic signed [rvq_pkg::CW-1:0] rx,
                          input logic signed [rvq_pkg::CW-1:0] ry,
                          input logic signed [rvq_pkg::CW-1:0] rz, input int idx);
    int gap;
    gap = ((idx / 50) % 3 == 1) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {rz, ry, rx};
    do @(negedge clk); while (!in_fire);
  endtask

  function automatic logic signed [rvq_pkg::CW-1:0] rand_comp();
    unique case ($urandom_range(0, 5))
      0: return 0;
      1: return 24'($signed($urandom_range(0, 64)) - 32);
      2: return 24'($signed($urandom_range(0, 2097152)) - 1048576);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [rvq_pkg::CW-1:0] a;
    logic signed [rvq_pkg::CW-1:0] b;
    logic signed [rvq_pkg::CW-1:0] c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_ident = 0;
    n_negw = 0;
    idle_cnt = 0;
    add_row(0, 0, 0, 1, {54'd0, 18'd65536});
    add_row(8388607, 8388607, 8388607, 0, '0);
    add_row(-8388608, -8388608, -8388608, 0, '0);
    add_row(8388607, -8388608, 8388607, 0, '0);
    add_row(8388607, 0, 0, 0, '0);
    add_row(-8388608, 0, 0, 0, '0);
    add_row(0, 8388607, 0, 0, '0);
    add_row(0, -8388608, 0, 0, '0);
    add_row(0, 0, 8388607, 0, '0);
    add_row(0, 0, -8388608, 0, '0);
    add_row(1, 0, 0, 0, '0);
    add_row(-1, 0, 0, 0, '0);
    add_row(0, 0, 1, 0, '0);
    add_row(1, -1, 1, 0, '0);
    add_row(3294199, 0, 0, 0, '0);
    add_row(3294200, 0, 0, 0, '0);
    add_row(-3294199, 0, 0, 0, '0);
    add_row(6588397, 0, 0, 0, '0);
    add_row(1647099, 0, 0, 0, '0);
    add_row(0, 4941298, 0, 0, '0);
    add_row(1048576, 1048576, 1048576, 0, '0);
    add_row(-1048576, 2097152, -524288, 0, '0);
    add_row(0, 0, 0, 1, {54'd0, 18'd65536});
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].typed) pend_q = {pend_q, rows[i].quat};
      else pend_q = {pend_q, predict_quat(rows[i].rx, rows[i].ry, rows[i].rz)};
      send_vec(rows[i].rx, rows[i].ry, rows[i].rz, i);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 600) begin
        in_tvalid = 1'b0;
        while (quat_q.size() != 0) @(negedge clk);
      end
      a = rand_comp();
      b = rand_comp();
      c = rand_comp();
      send_vec(a, b, c, i);
    end
    in_tvalid = 1'b0;
    while (quat_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("converted %0d vectors, %0d identity results, %0d with negative w",
             n_out, n_ident, n_negw);
    $display("covered extremes, zero length, angles near pi and 2pi, long output stall");
    if (errors == 0 && quat_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
